/* hdl/rbdi_pkg.sv */
// rbdi_pkg: shared types, constants and the micro-program of the damped integrator
// no dependencies; used by every module of the block
package rbdi_pkg;

    // number format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_INERTIA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_DAMPING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_DAMPING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_FLAGS  = 3'd5;

    // lock flag bit positions
    localparam int LOCK_TRANS = 0;
    localparam int LOCK_X     = 1;
    localparam int LOCK_Y     = 2;
    localparam int LOCK_ROT   = 3;

    // reset values (one over mass and inertia reset to 1.0)
    localparam logic [DATA_W-2:0] TIME_STEP_RESET = 31'd1092;
    localparam logic [DATA_W-2:0] INV_RESET       = 31'(64'd1 << FRAC_BITS);

    // micro-program length and step counter width
    localparam int PROG_LEN = 27;
    localparam int STEP_W   = $clog2(PROG_LEN + 1);

    typedef struct packed {
        logic [DATA_W-2:0]        time_step;
        logic [DATA_W-2:0]        inv_mass;
        logic [DATA_W-2:0]        inv_inertia;
        logic signed [DATA_W-1:0] lin_damping;
        logic signed [DATA_W-1:0] ang_damping;
        logic [3:0]               lock_flags;
    } cfg_t;

    typedef enum logic [1:0] {
        LANE_X,
        LANE_Y,
        LANE_A
    } lane_t;

    // multiplier operand sources, relative to the lane of the command
    typedef enum logic [3:0] {
        OPD_FORCE,
        OPD_INV,
        OPD_DAMP,
        OPD_STEP,
        OPD_SPEED,
        OPD_AVG,
        OPD_HAVG,
        OPD_TMP,
        OPD_DV,
        OPD_NV
    } opnd_t;

    typedef enum logic [1:0] {
        ADD_ACCEL,
        ADD_AVG,
        ADD_SPEED,
        ADD_NV
    } addend_t;

    typedef enum logic [1:0] {
        DST_TMP,
        DST_DV,
        DST_NV,
        DST_MV
    } dst_t;

    // what the write-back stage does with the registered product
    typedef enum logic [3:0] {
        POST_NONE,
        POST_ACCEL,
        POST_MUL,
        POST_MADD,
        POST_DOTD_LOAD,
        POST_DOTD_ADD,
        POST_DOTN_LOAD,
        POST_DOTN_ADD,
        POST_DECIDE_LIN,
        POST_DECIDE_ANG
    } post_t;

    typedef struct packed {
        lane_t   lane;
        opnd_t   opa;
        opnd_t   opb;
        post_t   post;
        dst_t    dst;
        addend_t addend;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic load_out;
        cmd_t cmd;
    } ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    localparam cmd_t CMD_NOP = '{
        lane: LANE_X, opa: OPD_FORCE, opb: OPD_FORCE,
        post: POST_NONE, dst: DST_TMP, addend: ADD_ACCEL
    };

    function automatic cmd_t mk_cmd(input lane_t l, input opnd_t a, input opnd_t b,
                                    input post_t p, input dst_t d, input addend_t s);
        cmd_t c;
        c.lane   = l;
        c.opa    = a;
        c.opb    = b;
        c.post   = p;
        c.dst    = d;
        c.addend = s;
        return c;
    endfunction

    // lanes are interleaved so that no command reads what the one before it writes
    function automatic cmd_t prog_cmd(input logic [STEP_W-1:0] step);
        cmd_t c;
        c = CMD_NOP;
        unique case (step)
            // new acceleration and trapezoid mean
            5'd0:  c = mk_cmd(LANE_X, OPD_FORCE, OPD_INV, POST_ACCEL, DST_TMP, ADD_ACCEL);
            5'd1:  c = mk_cmd(LANE_Y, OPD_FORCE, OPD_INV, POST_ACCEL, DST_TMP, ADD_ACCEL);
            5'd2:  c = mk_cmd(LANE_A, OPD_FORCE, OPD_INV, POST_ACCEL, DST_TMP, ADD_ACCEL);
            // mean plus damping term
            5'd3:  c = mk_cmd(LANE_X, OPD_SPEED, OPD_DAMP, POST_MADD, DST_TMP, ADD_AVG);
            5'd4:  c = mk_cmd(LANE_Y, OPD_SPEED, OPD_DAMP, POST_MADD, DST_TMP, ADD_AVG);
            5'd5:  c = mk_cmd(LANE_A, OPD_SPEED, OPD_DAMP, POST_MADD, DST_TMP, ADD_AVG);
            // damped speed
            5'd6:  c = mk_cmd(LANE_X, OPD_TMP, OPD_STEP, POST_MADD, DST_DV, ADD_SPEED);
            5'd7:  c = mk_cmd(LANE_Y, OPD_TMP, OPD_STEP, POST_MADD, DST_DV, ADD_SPEED);
            5'd8:  c = mk_cmd(LANE_A, OPD_TMP, OPD_STEP, POST_MADD, DST_DV, ADD_SPEED);
            // undamped speed
            5'd9:  c = mk_cmd(LANE_X, OPD_AVG, OPD_STEP, POST_MADD, DST_NV, ADD_SPEED);
            5'd10: c = mk_cmd(LANE_Y, OPD_AVG, OPD_STEP, POST_MADD, DST_NV, ADD_SPEED);
            5'd11: c = mk_cmd(LANE_A, OPD_AVG, OPD_STEP, POST_MADD, DST_NV, ADD_SPEED);
            // dot products against the old speed
            5'd12: c = mk_cmd(LANE_X, OPD_DV, OPD_SPEED, POST_DOTD_LOAD, DST_TMP, ADD_ACCEL);
            5'd13: c = mk_cmd(LANE_Y, OPD_DV, OPD_SPEED, POST_DOTD_ADD, DST_TMP, ADD_ACCEL);
            5'd14: c = mk_cmd(LANE_X, OPD_NV, OPD_SPEED, POST_DOTN_LOAD, DST_TMP, ADD_ACCEL);
            5'd15: c = mk_cmd(LANE_Y, OPD_NV, OPD_SPEED, POST_DOTN_ADD, DST_TMP, ADD_ACCEL);
            5'd16: c = mk_cmd(LANE_A, OPD_FORCE, OPD_FORCE, POST_DECIDE_ANG, DST_TMP,
                              ADD_ACCEL);
            // half mean times step
            5'd17: c = mk_cmd(LANE_X, OPD_HAVG, OPD_STEP, POST_MUL, DST_TMP, ADD_ACCEL);
            5'd18: c = mk_cmd(LANE_Y, OPD_HAVG, OPD_STEP, POST_MUL, DST_TMP, ADD_ACCEL);
            5'd19: c = mk_cmd(LANE_A, OPD_HAVG, OPD_STEP, POST_MUL, DST_TMP, ADD_ACCEL);
            5'd20: c = mk_cmd(LANE_X, OPD_FORCE, OPD_FORCE, POST_DECIDE_LIN, DST_TMP,
                              ADD_ACCEL);
            // times step again, kept in the nv slot
            5'd21: c = mk_cmd(LANE_X, OPD_TMP, OPD_STEP, POST_MUL, DST_NV, ADD_ACCEL);
            5'd22: c = mk_cmd(LANE_Y, OPD_TMP, OPD_STEP, POST_MUL, DST_NV, ADD_ACCEL);
            5'd23: c = mk_cmd(LANE_A, OPD_TMP, OPD_STEP, POST_MUL, DST_NV, ADD_ACCEL);
            // increment: new speed times step plus the quadratic term
            5'd24: c = mk_cmd(LANE_X, OPD_SPEED, OPD_STEP, POST_MADD, DST_MV, ADD_NV);
            5'd25: c = mk_cmd(LANE_Y, OPD_SPEED, OPD_STEP, POST_MADD, DST_MV, ADD_NV);
            5'd26: c = mk_cmd(LANE_A, OPD_SPEED, OPD_STEP, POST_MADD, DST_MV, ADD_NV);
            default: c = CMD_NOP;
        endcase
        return c;
    endfunction

endpackage

/* hdl/rigid_body_damped_integrator_unit.sv */
// rigid_body_damped_integrator_unit: top level of the damped 2d rigid-body integrator
// depends on rbdi_pkg, rbdi_cfg, rbdi_ctrl, rbdi_dp
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_ready  | force_x, force_y, torque_in (q16.16 signed)
//  result   | out_valid / out_ready| move_x, move_y, turn, vel_x, vel_y, spin, saturated
//  config   | cfg_valid / cfg_ready| cfg_index (3 bits), cfg_data (32 bits)
//
//  a request is taken in the idle state; the 27-command micro-program then runs through
//  the single shared 32x32 multiplier (one command a cycle, then the write-back of the last
//  one); the finish state moves the result out and the block goes back to idle, where the
//  next request is accepted; the result and out_valid are registered together
//  a new request is taken while the previous result still waits; the block only holds at
//  the end of the program if that result has not yet been taken
//  asynchronous active-low reset clears the body state and restores the register defaults
//  config writes are always ready and take effect on the following cycle
module rigid_body_damped_integrator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rbdi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbdi_pkg::DATA_W-1:0]         cfg_data,
    // force and torque requests
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  force_x,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  force_y,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  torque_in,
    // step results
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rbdi_pkg::DATA_W-1:0]  move_x,
    output logic signed [rbdi_pkg::DATA_W-1:0]  move_y,
    output logic signed [rbdi_pkg::DATA_W-1:0]  turn,
    output logic signed [rbdi_pkg::DATA_W-1:0]  vel_x,
    output logic signed [rbdi_pkg::DATA_W-1:0]  vel_y,
    output logic signed [rbdi_pkg::DATA_W-1:0]  spin,
    output logic                                saturated
);

    // register bank to datapath
    rbdi_pkg::cfg_t  cfg;
    // sequencer commands to datapath
    rbdi_pkg::ctrl_t ctrl;

    // step length, reciprocals, damping and lock flags
    rbdi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state machine: idle, run the program, hand the result over
    rbdi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    // shared multiplier with saturating write-back and the body state
    rbdi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg),
        .force_x   (force_x),
        .force_y   (force_y),
        .torque_in (torque_in),
        .move_x    (move_x),
        .move_y    (move_y),
        .turn      (turn),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .spin      (spin),
        .saturated (saturated)
    );

endmodule

/* hdl/rbdi_cfg.sv */
// rbdi_cfg: configuration register bank with its write channel
// depends on rbdi_pkg
module rbdi_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rbdi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbdi_pkg::DATA_W-1:0]      cfg_data,
    output rbdi_pkg::cfg_t                   cfg
);

    rbdi_pkg::cfg_t cfg_reg;
    rbdi_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rbdi_pkg::CFG_TIME_STEP:   cfg_next.time_step   = cfg_data[rbdi_pkg::DATA_W-2:0];
                rbdi_pkg::CFG_INV_MASS:    cfg_next.inv_mass    = cfg_data[rbdi_pkg::DATA_W-2:0];
                rbdi_pkg::CFG_INV_INERTIA: cfg_next.inv_inertia = cfg_data[rbdi_pkg::DATA_W-2:0];
                rbdi_pkg::CFG_LIN_DAMPING: cfg_next.lin_damping = cfg_data;
                rbdi_pkg::CFG_ANG_DAMPING: cfg_next.ang_damping = cfg_data;
                rbdi_pkg::CFG_LOCK_FLAGS:  cfg_next.lock_flags  = cfg_data[3:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step   <= rbdi_pkg::TIME_STEP_RESET;
            cfg_reg.inv_mass    <= rbdi_pkg::INV_RESET;
            cfg_reg.inv_inertia <= rbdi_pkg::INV_RESET;
            cfg_reg.lin_damping <= '0;
            cfg_reg.ang_damping <= '0;
            cfg_reg.lock_flags  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/rbdi_ctrl.sv */
// rbdi_ctrl: sequencer that walks the micro-program and runs both handshakes
// depends on rbdi_pkg
module rbdi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output rbdi_pkg::ctrl_t     ctrl
);

    rbdi_pkg::state_t                 state_reg;
    rbdi_pkg::state_t                 state_next;
    logic [rbdi_pkg::STEP_W-1:0]      step_reg;
    logic [rbdi_pkg::STEP_W-1:0]      step_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            rbdi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rbdi_pkg::ST_RUN;
                    step_next  = '0;
                end
            end
            rbdi_pkg::ST_RUN:
            begin
                if (step_reg == rbdi_pkg::STEP_W'(rbdi_pkg::PROG_LEN))
                    state_next = rbdi_pkg::ST_FINISH;
                else
                    step_next = step_reg + 1'b1;
            end
            rbdi_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next     = rbdi_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = rbdi_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        ctrl.start    = 1'b0;
        ctrl.load_out = 1'b0;
        ctrl.cmd      = rbdi_pkg::CMD_NOP;
        unique case (state_reg)
            rbdi_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctrl.start = in_valid;
            end
            rbdi_pkg::ST_RUN:    ctrl.cmd      = rbdi_pkg::prog_cmd(step_reg);
            rbdi_pkg::ST_FINISH: ctrl.load_out = out_free;
            default:             in_ready      = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbdi_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/rbdi_dp.sv */
// rbdi_dp: shared multiplier, write-back stage, per-lane registers and result register
// depends on rbdi_pkg
module rbdi_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rbdi_pkg::ctrl_t                     ctrl,
    input  rbdi_pkg::cfg_t                      cfg,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  force_x,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  force_y,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  torque_in,
    output logic signed [rbdi_pkg::DATA_W-1:0]  move_x,
    output logic signed [rbdi_pkg::DATA_W-1:0]  move_y,
    output logic signed [rbdi_pkg::DATA_W-1:0]  turn,
    output logic signed [rbdi_pkg::DATA_W-1:0]  vel_x,
    output logic signed [rbdi_pkg::DATA_W-1:0]  vel_y,
    output logic signed [rbdi_pkg::DATA_W-1:0]  spin,
    output logic                                saturated
);

    localparam int W  = rbdi_pkg::DATA_W;
    localparam int PW = rbdi_pkg::PROD_W;

    // saturating helpers, flag in the top bit
    function automatic logic [W:0] sat_mul(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] sh;
        logic [W:0]           r;
        sh = p >>> rbdi_pkg::FRAC_BITS;
        if (sh > PW'(signed'({1'b0, {(W-1){1'b1}}})))
            r = {1'b1, 1'b0, {(W-1){1'b1}}};
        else if (sh < -PW'(signed'({1'b0, 1'b1, {(W-1){1'b0}}})))
            r = {1'b1, 1'b1, {(W-1){1'b0}}};
        else
            r = {1'b0, sh[W-1:0]};
        return r;
    endfunction

    function automatic logic [W:0] sat_add(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b);
        logic signed [W:0] s;
        logic [W:0]        r;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            r = {1'b1, s[W], {(W-1){!s[W]}}};
        else
            r = {1'b0, s[W-1:0]};
        return r;
    endfunction

    function automatic logic signed [W-1:0] pick(
        input rbdi_pkg::opnd_t        code,
        input logic signed [W-1:0]    f_l,
        input logic signed [W-1:0]    inv_l,
        input logic signed [W-1:0]    damp_l,
        input logic signed [W-1:0]    step_l,
        input logic signed [W-1:0]    spd_l,
        input logic signed [W-1:0]    avg_l,
        input logic signed [W-1:0]    tmp_l,
        input logic signed [W-1:0]    dv_l,
        input logic signed [W-1:0]    nv_l);
        logic signed [W-1:0] v;
        unique case (code)
            rbdi_pkg::OPD_FORCE: v = f_l;
            rbdi_pkg::OPD_INV:   v = inv_l;
            rbdi_pkg::OPD_DAMP:  v = damp_l;
            rbdi_pkg::OPD_STEP:  v = step_l;
            rbdi_pkg::OPD_SPEED: v = spd_l;
            rbdi_pkg::OPD_AVG:   v = avg_l;
            rbdi_pkg::OPD_HAVG:  v = avg_l >>> 1;
            rbdi_pkg::OPD_TMP:   v = tmp_l;
            rbdi_pkg::OPD_DV:    v = dv_l;
            rbdi_pkg::OPD_NV:    v = nv_l;
            default:             v = f_l;
        endcase
        return v;
    endfunction

    // per-lane registers: x, y, angle
    logic signed [W-1:0]  force_reg [3];
    logic signed [W-1:0]  accel_reg [3];
    logic signed [W-1:0]  speed_reg [3];
    logic signed [W-1:0]  avg_reg   [3];
    logic signed [W-1:0]  tmp_reg   [3];
    logic signed [W-1:0]  dv_reg    [3];
    logic signed [W-1:0]  nv_reg    [3];
    logic signed [W-1:0]  mv_reg    [3];

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [W-1:0]  addend_reg;
    logic signed [W-1:0]  addend_next;
    rbdi_pkg::cmd_t       wb_reg;
    logic signed [PW:0]   dsum_reg;
    logic signed [PW:0]   nsum_reg;
    logic                 sat_reg;

    logic [1:0]           il;
    logic [1:0]           wl;
    logic signed [W-1:0]  inv_l;
    logic signed [W-1:0]  damp_l;
    logic signed [W-1:0]  step_val;
    logic signed [W-1:0]  opa_val;
    logic signed [W-1:0]  opb_val;

    logic [W:0]           m_res;
    logic [W:0]           a_res;
    logic signed [W-1:0]  m_val;
    logic signed [W-1:0]  a_val;
    logic signed [W-1:0]  wr_val;
    logic signed [W:0]    avg_sum;
    logic signed [PW:0]   raw;
    logic                 wb_en;
    logic                 keep_lin;
    logic                 dv_a_pos;
    logic                 nv_a_pos;

    // issue side: one lane read, one multiply
    assign il       = ctrl.cmd.lane;
    assign inv_l    = (ctrl.cmd.lane == rbdi_pkg::LANE_A) ? W'({1'b0, cfg.inv_inertia})
                                                          : W'({1'b0, cfg.inv_mass});
    assign damp_l   = (ctrl.cmd.lane == rbdi_pkg::LANE_A) ? cfg.ang_damping : cfg.lin_damping;
    assign step_val = W'({1'b0, cfg.time_step});

    assign opa_val = pick(ctrl.cmd.opa, force_reg[il], inv_l, damp_l, step_val,
                          speed_reg[il], avg_reg[il], tmp_reg[il], dv_reg[il], nv_reg[il]);
    assign opb_val = pick(ctrl.cmd.opb, force_reg[il], inv_l, damp_l, step_val,
                          speed_reg[il], avg_reg[il], tmp_reg[il], dv_reg[il], nv_reg[il]);
    assign prod_next = opa_val * opb_val;

    always_comb
    begin
        unique case (ctrl.cmd.addend)
            rbdi_pkg::ADD_ACCEL: addend_next = accel_reg[il];
            rbdi_pkg::ADD_AVG:   addend_next = avg_reg[il];
            rbdi_pkg::ADD_SPEED: addend_next = speed_reg[il];
            rbdi_pkg::ADD_NV:    addend_next = nv_reg[il];
            default:             addend_next = accel_reg[il];
        endcase
    end

    // write-back side
    assign wl      = wb_reg.lane;
    assign wb_en   = (wb_reg.lane == rbdi_pkg::LANE_A) ? !cfg.lock_flags[rbdi_pkg::LOCK_ROT]
                                                       : !cfg.lock_flags[rbdi_pkg::LOCK_TRANS];
    assign m_res   = sat_mul(prod_reg);
    assign m_val   = m_res[W-1:0];
    assign a_res   = sat_add(m_val, addend_reg);
    assign a_val   = a_res[W-1:0];
    assign wr_val  = (wb_reg.post == rbdi_pkg::POST_MADD) ? a_val : m_val;
    assign avg_sum = {addend_reg[W-1], addend_reg} + {m_val[W-1], m_val};
    assign raw     = {prod_reg[PW-1], prod_reg};

    // damped and undamped speeds agree on direction
    assign keep_lin = (dsum_reg[PW] == nsum_reg[PW]);
    assign dv_a_pos = !dv_reg[2][W-1] && (dv_reg[2] != '0);
    assign nv_a_pos = !nv_reg[2][W-1] && (nv_reg[2] != '0);

    // architectural state and flags; a start only ever meets an empty write-back slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                accel_reg[i] <= '0;
                speed_reg[i] <= '0;
            end
            wb_reg  <= rbdi_pkg::CMD_NOP;
            sat_reg <= 1'b0;
        end
        else
        begin
            wb_reg <= ctrl.cmd;
            unique case (wb_reg.post)
                rbdi_pkg::POST_ACCEL:
                begin
                    if (wb_en)
                    begin
                        accel_reg[wl] <= m_val;
                        sat_reg       <= sat_reg | m_res[W];
                    end
                end
                rbdi_pkg::POST_MUL:
                begin
                    if (wb_en)
                        sat_reg <= sat_reg | m_res[W];
                end
                rbdi_pkg::POST_MADD:
                begin
                    if (wb_en)
                        sat_reg <= sat_reg | m_res[W] | a_res[W];
                end
                rbdi_pkg::POST_DECIDE_LIN:
                begin
                    if (!cfg.lock_flags[rbdi_pkg::LOCK_TRANS] && keep_lin)
                    begin
                        speed_reg[0] <= dv_reg[0];
                        speed_reg[1] <= dv_reg[1];
                    end
                    else
                    begin
                        speed_reg[0] <= '0;
                        speed_reg[1] <= '0;
                    end
                end
                rbdi_pkg::POST_DECIDE_ANG:
                begin
                    if (!cfg.lock_flags[rbdi_pkg::LOCK_ROT] && (dv_a_pos == nv_a_pos))
                        speed_reg[2] <= dv_reg[2];
                    else
                        speed_reg[2] <= '0;
                end
                default: sat_reg <= ctrl.start ? 1'b0 : sat_reg;
            endcase
        end
    end

    // working registers and result register
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        addend_reg <= addend_next;
        if (ctrl.start)
        begin
            force_reg[0] <= force_x;
            force_reg[1] <= force_y;
            force_reg[2] <= torque_in;
        end
        unique case (wb_reg.post)
            rbdi_pkg::POST_ACCEL:
            begin
                if (wb_en)
                    avg_reg[wl] <= avg_sum[W:1];
            end
            rbdi_pkg::POST_MUL, rbdi_pkg::POST_MADD:
            begin
                if (wb_en)
                begin
                    unique case (wb_reg.dst)
                        rbdi_pkg::DST_TMP: tmp_reg[wl] <= wr_val;
                        rbdi_pkg::DST_DV:  dv_reg[wl]  <= wr_val;
                        rbdi_pkg::DST_NV:  nv_reg[wl]  <= wr_val;
                        rbdi_pkg::DST_MV:  mv_reg[wl]  <= wr_val;
                        default:           tmp_reg[wl] <= wr_val;
                    endcase
                end
            end
            rbdi_pkg::POST_DOTD_LOAD: dsum_reg <= raw;
            rbdi_pkg::POST_DOTD_ADD:  dsum_reg <= dsum_reg + raw;
            rbdi_pkg::POST_DOTN_LOAD: nsum_reg <= raw;
            rbdi_pkg::POST_DOTN_ADD:  nsum_reg <= nsum_reg + raw;
            default:                  dsum_reg <= dsum_reg;
        endcase
        if (ctrl.load_out)
        begin
            move_x <= (cfg.lock_flags[rbdi_pkg::LOCK_TRANS] || cfg.lock_flags[rbdi_pkg::LOCK_X])
                      ? '0 : mv_reg[0];
            move_y <= (cfg.lock_flags[rbdi_pkg::LOCK_TRANS] || cfg.lock_flags[rbdi_pkg::LOCK_Y])
                      ? '0 : mv_reg[1];
            turn   <= cfg.lock_flags[rbdi_pkg::LOCK_ROT] ? '0 : mv_reg[2];
            vel_x  <= speed_reg[0];
            vel_y  <= speed_reg[1];
            spin   <= speed_reg[2];
            saturated <= sat_reg;
        end
    end

endmodule

/* hdl/rbdi_checker.sv */
// rbdi_checker: port-level assertions for the damped integrator, bound to the top level
// depends on rbdi_pkg and rigid_body_damped_integrator_unit
module rbdi_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_ready,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [rbdi_pkg::DATA_W-1:0]  move_x,
    input logic signed [rbdi_pkg::DATA_W-1:0]  spin
);

    // a stalled result stays valid and holds its move_x and spin payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(move_x) && $stable(spin)))
        else $error("result changed while stalled");

    // one request at a time: busy right after taking one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while busy");

    // a fresh request cannot produce a result in the next cycle
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result appeared too early");

    // config writes never stall
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port stalled");

endmodule

bind rigid_body_damped_integrator_unit rbdi_checker u_rbdi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .move_x    (move_x),
    .spin      (spin)
);

/* tb/rbdi_step_checker.sv */
// rbdi_step_checker: watches the register, request and result channels of the integrator,
// keeps its own body state and register copy, predicts each step result and compares it
// depends on rbdi_pkg for widths, register indexes, lock bit positions and reset values
module rbdi_step_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rbdi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbdi_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  force_x,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  force_y,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  torque_in,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  move_x,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  move_y,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  turn,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  vel_x,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  vel_y,
    input  logic signed [rbdi_pkg::DATA_W-1:0]  spin,
    input  logic                                saturated,
    output int                                  fails,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [rbdi_pkg::DATA_W-1:0] fx_t;

    typedef struct {
        fx_t  move_x;
        fx_t  move_y;
        fx_t  turn;
        fx_t  vel_x;
        fx_t  vel_y;
        fx_t  spin;
        logic sat;
    } motion_t;

    localparam longint FX_MAX = 64'sd2147483647;
    localparam longint FX_MIN = -64'sd2147483648;

    // register copy
    logic [rbdi_pkg::DATA_W-2:0] step_len;
    logic [rbdi_pkg::DATA_W-2:0] inv_m;
    logic [rbdi_pkg::DATA_W-2:0] inv_i;
    fx_t                         damp_lin;
    fx_t                         damp_rot;
    logic [3:0]                  locks;

    // body state
    fx_t lin_acc [2];
    fx_t lin_vel [2];
    fx_t rot_acc;
    fx_t rot_vel;

    logic    sat_seen;
    motion_t motion_q [$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      waiting = 0;

    assign fails       = mismatches;
    assign outstanding = waiting;

    function automatic fx_t clamp(input longint v);
        if (v > FX_MAX)
        begin
            sat_seen = 1'b1;
            return fx_t'(FX_MAX);
        end
        if (v < FX_MIN)
        begin
            sat_seen = 1'b1;
            return fx_t'(FX_MIN);
        end
        return fx_t'(v);
    endfunction

    // exact product, floor shift, then saturate
    function automatic fx_t qmul(input longint a, input longint b);
        return clamp((a * b) >>> rbdi_pkg::FRAC_BITS);
    endfunction

    function automatic fx_t qadd(input fx_t a, input fx_t b);
        return clamp(longint'(a) + longint'(b));
    endfunction

    function automatic motion_t advance_body(input fx_t fx, input fx_t fy, input fx_t tq);
        motion_t r;
        fx_t     frc [2];
        fx_t     avg [2];
        fx_t     dv [2];
        fx_t     nv [2];
        fx_t     mv [2];
        longint  dp [2];
        longint  np [2];
        longint  t;
        fx_t     prev;
        fx_t     term;
        fx_t     q;
        fx_t     ravg;
        fx_t     rdv;
        fx_t     rnv;
        fx_t     tr;
        int      i;
        frc[0]   = fx;
        frc[1]   = fy;
        mv[0]    = '0;
        mv[1]    = '0;
        tr       = '0;
        t        = longint'(step_len);
        sat_seen = 1'b0;

        if (!locks[rbdi_pkg::LOCK_TRANS])
        begin
            for (i = 0; i < 2; i++)
            begin
                prev       = lin_acc[i];
                lin_acc[i] = qmul(frc[i], inv_m);
                avg[i]     = fx_t'((longint'(prev) + longint'(lin_acc[i])) >>> 1);
                term       = qadd(avg[i], qmul(lin_vel[i], damp_lin));
                dv[i]      = qadd(lin_vel[i], qmul(term, t));
                nv[i]      = qadd(lin_vel[i], qmul(avg[i], t));
                dp[i]      = longint'(dv[i]) * longint'(lin_vel[i]);
                np[i]      = longint'(nv[i]) * longint'(lin_vel[i]);
            end
            // damping that flips the direction of travel stops the body
            if ((dp[0] >= -dp[1]) == (np[0] >= -np[1]))
            begin
                lin_vel[0] = dv[0];
                lin_vel[1] = dv[1];
            end
            else
            begin
                lin_vel[0] = '0;
                lin_vel[1] = '0;
            end
            for (i = 0; i < 2; i++)
            begin
                q     = qmul(qmul(avg[i] >>> 1, t), t);
                mv[i] = qadd(qmul(lin_vel[i], t), q);
            end
            if (locks[rbdi_pkg::LOCK_X])
                mv[0] = '0;
            if (locks[rbdi_pkg::LOCK_Y])
                mv[1] = '0;
        end
        else
        begin
            lin_vel[0] = '0;
            lin_vel[1] = '0;
        end

        if (!locks[rbdi_pkg::LOCK_ROT])
        begin
            prev    = rot_acc;
            rot_acc = qmul(tq, inv_i);
            ravg    = fx_t'((longint'(prev) + longint'(rot_acc)) >>> 1);
            term    = qadd(ravg, qmul(rot_vel, damp_rot));
            rdv     = qadd(rot_vel, qmul(term, t));
            rnv     = qadd(rot_vel, qmul(ravg, t));
            rot_vel = ((rdv > 0) == (rnv > 0)) ? rdv : fx_t'(0);
            q       = qmul(qmul(ravg >>> 1, t), t);
            tr      = qadd(qmul(rot_vel, t), q);
        end
        else
            rot_vel = '0;

        r.move_x = mv[0];
        r.move_y = mv[1];
        r.turn   = tr;
        r.vel_x  = lin_vel[0];
        r.vel_y  = lin_vel[1];
        r.spin   = rot_vel;
        r.sat    = sat_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        motion_t want;
        if (!rst_n)
        begin
            step_len   = rbdi_pkg::TIME_STEP_RESET;
            inv_m      = rbdi_pkg::INV_RESET;
            inv_i      = rbdi_pkg::INV_RESET;
            damp_lin   = '0;
            damp_rot   = '0;
            locks      = '0;
            lin_acc[0] = '0;
            lin_acc[1] = '0;
            lin_vel[0] = '0;
            lin_vel[1] = '0;
            rot_acc    = '0;
            rot_vel    = '0;
            motion_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rbdi_pkg::CFG_TIME_STEP:   step_len = cfg_data[rbdi_pkg::DATA_W-2:0];
                    rbdi_pkg::CFG_INV_MASS:    inv_m    = cfg_data[rbdi_pkg::DATA_W-2:0];
                    rbdi_pkg::CFG_INV_INERTIA: inv_i    = cfg_data[rbdi_pkg::DATA_W-2:0];
                    rbdi_pkg::CFG_LIN_DAMPING: damp_lin = cfg_data;
                    rbdi_pkg::CFG_ANG_DAMPING: damp_rot = cfg_data;
                    rbdi_pkg::CFG_LOCK_FLAGS:  locks    = cfg_data[3:0];
                    default:                   ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                results_seen++;
                if (motion_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no request outstanding",
                                 results_seen);
                end
                else
                begin
                    want = motion_q.pop_front();
                    if (move_x !== want.move_x || move_y !== want.move_y ||
                        turn !== want.turn || vel_x !== want.vel_x ||
                        vel_y !== want.vel_y || spin !== want.spin ||
                        saturated !== want.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d wrong: move %h %h turn %h vel %h %h spin %h sat %b",
                                     results_seen, move_x, move_y, turn, vel_x, vel_y, spin,
                                     saturated);
                            $display("    expected:  move %h %h turn %h vel %h %h spin %h sat %b",
                                     want.move_x, want.move_y, want.turn, want.vel_x,
                                     want.vel_y, want.spin, want.sat);
                        end
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                want = advance_body(force_x, force_y, torque_in);
                motion_q.insert(motion_q.size(), want);
            end
        end
        waiting = motion_q.size();
    end

endmodule

/* tb/rigid_body_damped_integrator_unit_tb.sv */
// rigid_body_damped_integrator_unit_tb: drives force and torque requests and register
// writes into the damped integrator, with rbdi_step_checker beside it doing the prediction
// depends on rbdi_pkg, rigid_body_damped_integrator_unit and rbdi_step_checker
module rigid_body_damped_integrator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [rbdi_pkg::DATA_W-1:0] fx_t;

    // register indexes past the end of the map, writes there must change nothing
    localparam logic [rbdi_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [rbdi_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // a request is busy while the micro-program runs or its result waits; idle runs on either
    // side are short random stretches, so QUIET_LIMIT quiet cycles in a row must mean a hang
    localparam int QUIET_LIMIT = 1000;

    // results show only after the micro-program has run, so let DRAIN_CYCLES pass at the end
    localparam int DRAIN_CYCLES = 40;

    // random part: three idling mixes, four register settings each
    localparam int BLOCK_ITEMS = 104;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rbdi_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rbdi_pkg::DATA_W-1:0]     cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    fx_t                             force_x   = '0;
    fx_t                             force_y   = '0;
    fx_t                             torque_in = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    fx_t                             move_x;
    fx_t                             move_y;
    fx_t                             turn;
    fx_t                             vel_x;
    fx_t                             vel_y;
    fx_t                             spin;
    logic                            saturated;

    int fails;
    int outstanding;

    // percentage of cycles in which each side holds back
    int send_idle  = 27;
    int recv_idle  = 59;
    int quiet      = 0;

    always #6 clk = ~clk;

    rigid_body_damped_integrator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .force_x   (force_x),
        .force_y   (force_y),
        .torque_in (torque_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .move_x    (move_x),
        .move_y    (move_y),
        .turn      (turn),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .spin      (spin),
        .saturated (saturated)
    );

    rbdi_step_checker step_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .force_x     (force_x),
        .force_y     (force_y),
        .torque_in   (torque_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .move_x      (move_x),
        .move_y      (move_y),
        .turn        (turn),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .spin        (spin),
        .saturated   (saturated),
        .fails       (fails),
        .outstanding (outstanding)
    );

    // result side: holds back in each cycle at the current rate
    always @(posedge clk)
    begin
        if ($urandom_range(99) < recv_idle)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // watchdog: counts cycles in which no channel moves anything
    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // mostly modest forces so that speeds build up over many steps without clipping,
    // with full-range words and the corner values mixed in
    function automatic fx_t pick_force();
        int unsigned r;
        fx_t         v;
        r = $urandom_range(99);
        if (r < 55)
            v = fx_t'(int'($urandom_range(1 << 21, 0)) - (1 << 20));
        else if (r < 80)
            v = fx_t'(int'($urandom_range(1 << 27, 0)) - (1 << 26));
        else if (r < 92)
            v = fx_t'($urandom);
        else
        begin
            case ($urandom_range(4))
                0:       v = '0;
                1:       v = 32'sh7fff_ffff;
                2:       v = 32'sh8000_0000;
                3:       v = 32'sd1;
                default: v = -32'sd1;
            endcase
        end
        return v;
    endfunction

    // reciprocal mass or inertia: realistic spread, zero, full scale, random words and unit
    function automatic logic [rbdi_pkg::DATA_W-2:0] pick_inv();
        logic [rbdi_pkg::DATA_W-2:0] v;
        case ($urandom_range(9))
            6:       v = '0;
            7:       v = 31'h7fff_ffff;
            8:       v = 31'($urandom);
            9:       v = 31'(1 << rbdi_pkg::FRAC_BITS);
            default: v = 31'($urandom_range(1 << 20, 1 << 10));
        endcase
        return v;
    endfunction

    // strong negative damping makes the damped update overshoot and flip direction
    function automatic logic [rbdi_pkg::DATA_W-1:0] pick_damp();
        logic [rbdi_pkg::DATA_W-1:0] v;
        case ($urandom_range(9))
            4, 5:    v = 32'($urandom_range(4 << 16, 0));
            6:       v = '0;
            7:       v = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            8:       v = $urandom;
            9:       v = 32'(-int'($urandom_range(1 << 16, 0)));
            default: v = 32'(-int'($urandom_range(200 << 16, 0)));
        endcase
        return v;
    endfunction

    // one register write; valid is left high, the caller drops it after the last one
    task automatic write_reg(input logic [rbdi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rbdi_pkg::DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // full register set; unused upper data bits are filled with noise
    task automatic configure(input logic [rbdi_pkg::DATA_W-2:0] ts,
                             input logic [rbdi_pkg::DATA_W-2:0] im,
                             input logic [rbdi_pkg::DATA_W-2:0] ii,
                             input logic [rbdi_pkg::DATA_W-1:0] ld,
                             input logic [rbdi_pkg::DATA_W-1:0] ad, input logic [3:0] lk);
        write_reg(rbdi_pkg::CFG_TIME_STEP,   {1'($urandom), ts});
        write_reg(rbdi_pkg::CFG_INV_MASS,    {1'($urandom), im});
        write_reg(rbdi_pkg::CFG_INV_INERTIA, {1'($urandom), ii});
        write_reg(rbdi_pkg::CFG_LIN_DAMPING, ld);
        write_reg(rbdi_pkg::CFG_ANG_DAMPING, ad);
        write_reg(rbdi_pkg::CFG_LOCK_FLAGS,  {28'($urandom), lk});
        cfg_valid <= 1'b0;
    endtask

    // one force request after idle cycles drawn at the current rate; valid stays high
    // for a following request
    task automatic push_force(input fx_t fx, input fx_t fy, input fx_t tq);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        force_x   <= fx;
        force_y   <= fy;
        torque_in <= tq;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending and wait until every request has produced its result
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [3:0] lock_mix [5];
        int         ph;
        int         blk;
        int         k;
        int         r;
        logic [rbdi_pkg::DATA_W-2:0] ts;

        lock_mix[0] = 4'(1 << rbdi_pkg::LOCK_TRANS);
        lock_mix[1] = 4'(1 << rbdi_pkg::LOCK_X);
        lock_mix[2] = 4'(1 << rbdi_pkg::LOCK_Y);
        lock_mix[3] = 4'(1 << rbdi_pkg::LOCK_ROT);
        lock_mix[4] = 4'hf;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults straight after reset: rest, tiny and full-scale forces
        push_force('0, '0, '0);
        push_force(32'sd1, -32'sd1, 32'sd1);
        push_force(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        push_force(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
        push_force(32'sd65536, -32'sd65536, 32'sd32768);

        // step and reciprocals at their top end, damping at both signed extremes, no locks
        settle();
        configure(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 4'h0);
        push_force(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        push_force(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);

        // zero step and zero reciprocals
        settle();
        configure('0, '0, '0, 32'h7fff_ffff, 32'h8000_0000, 4'h0);
        push_force(32'sd12345, -32'sd12345, 32'sd777);

        // one second steps with damping of minus three: the body gets moving, then the
        // damped update overshoots past zero and the speed and spin are cleared
        settle();
        configure(31'(1 << rbdi_pkg::FRAC_BITS), 31'(1 << rbdi_pkg::FRAC_BITS),
                  31'(1 << rbdi_pkg::FRAC_BITS), 32'(-(3 << rbdi_pkg::FRAC_BITS)),
                  32'(-(3 << rbdi_pkg::FRAC_BITS)), 4'h0);
        push_force(32'sd65536, -32'sd32768, 32'sd65536);
        push_force('0, '0, '0);
        push_force('0, '0, '0);
        push_force('0, '0, '0);

        // each lock on its own and all together
        for (k = 0; k < 5; k++)
        begin
            settle();
            configure(31'(1 << 14), 31'(1 << rbdi_pkg::FRAC_BITS), 31'(1 << 15),
                      32'(-(1 << 14)), 32'(1 << 13), lock_mix[k]);
            push_force(32'sd200000, -32'sd150000, 32'sd90000);
            push_force(-32'sd50000, 32'sd70000, -32'sd120000);
        end

        // writes past the register map must leave everything as it was
        settle();
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
        push_force(32'sd300000, 32'sd300000, -32'sd300000);

        // random part: receiver-heavy idling, then sender-heavy, then none at all
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 27;
                    recv_idle = 59;
                end
                1:
                begin
                    send_idle = 59;
                    recv_idle = 27;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (blk = 0; blk < 4; blk++)
            begin
                settle();
                r = $urandom_range(9);
                case (r)
                    6:       ts = '0;
                    7:       ts = 31'h7fff_ffff;
                    8:       ts = 31'($urandom);
                    9:       ts = 31'($urandom_range(16, 1));
                    default: ts = 31'($urandom_range(1 << 17, 1));
                endcase
                configure(ts, pick_inv(), pick_inv(), pick_damp(), pick_damp(),
                          ($urandom_range(9) < 6) ? 4'h0 : 4'($urandom));
                repeat (BLOCK_ITEMS)
                    push_force(pick_force(), pick_force(), pick_force());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
